[src/tlq_pkg.sv]
// Shared types, constants and codes for the target lock qualifier.
package tlq_pkg;

   // Sizing
   localparam int LOCK_COUNT = 5;
   localparam int COORD_BITS = 12;
   localparam int FRAC_BITS  = 4;
   localparam int EST_W      = COORD_BITS + FRAC_BITS;
   localparam int CROP_W     = COORD_BITS + 1;
   localparam int MOVE_W     = EST_W + 3;

   // Port field widths
   localparam int FIELD_W    = 12;
   localparam int EDGE_W     = 13;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 12;

   // Register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_FRAME_WIDTH  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_FRAME_HEIGHT = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_CHROMA_MODE  = 2'd2;

   // Register reset values
   localparam logic [CSR_DATA_W-1:0] FRAME_WIDTH_RESET  = 12'd640;
   localparam logic [CSR_DATA_W-1:0] FRAME_HEIGHT_RESET = 12'd480;
   localparam logic                  CHROMA_MODE_RESET  = 1'b1;

   typedef enum logic [1:0] {
      EV_NONE    = 2'd0,
      EV_RESET   = 2'd1,
      EV_LOCK    = 2'd2,
      EV_TRIGGER = 2'd3
   } event_type;

   typedef logic [COORD_BITS-1:0] coord_type;
   typedef logic [EST_W-1:0]      est_type;
   typedef logic [CROP_W-1:0]     crop_type;

   typedef struct packed {
      logic                object_present;
      logic [FIELD_W-1:0]  center_x;
      logic [FIELD_W-1:0]  center_y;
      logic [FIELD_W-1:0]  obj_width;
      logic [FIELD_W-1:0]  obj_height;
   } req_type;

   typedef struct packed {
      logic [1:0]          event_res;
      logic                is_locked;
      logic [2:0]          lock_progress;
      logic [EDGE_W-1:0]   crop_left;
      logic [EDGE_W-1:0]   crop_top;
      logic [EDGE_W-1:0]   crop_right;
      logic [EDGE_W-1:0]   crop_bottom;
      logic [FIELD_W-1:0]  est_x;
      logic [FIELD_W-1:0]  est_y;
   } rsp_type;

   typedef struct packed {
      logic [CSR_DATA_W-1:0] frame_width;
      logic [CSR_DATA_W-1:0] frame_height;
      logic                  chroma_mode;
   } cfg_type;

   typedef struct packed {
      est_type    est_x;
      est_type    est_y;
      est_type    est_w;
      est_type    est_h;
      logic [2:0] lock_count;
      logic       locked;
      logic       just_locked;
      crop_type   crop_left;
      crop_type   crop_top;
      crop_type   crop_right;
      crop_type   crop_bottom;
   } state_type;

endpackage

[src/tlq_csr.sv]
// Configuration registers of the target lock qualifier.
module tlq_csr
   import tlq_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_write_enable,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_data,
   output cfg_type               cfg
);

   cfg_type cfg_ff;
   cfg_type cfg_in;

   // Write the addressed register, drop unknown indexes
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write_enable) begin
         case (csr_index)
            CSR_FRAME_WIDTH:  cfg_in.frame_width  = csr_data;
            CSR_FRAME_HEIGHT: cfg_in.frame_height = csr_data;
            CSR_CHROMA_MODE:  cfg_in.chroma_mode  = csr_data[0];
            default:          cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.frame_width  <= FRAME_WIDTH_RESET;
         cfg_ff.frame_height <= FRAME_HEIGHT_RESET;
         cfg_ff.chroma_mode  <= CHROMA_MODE_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

[src/tlq_update.sv]
// Next-state and result logic for one detection of the target lock qualifier.
module tlq_update
   import tlq_pkg::*;
(
   input  state_type cur,
   input  req_type   req,
   input  cfg_type   cfg,
   output state_type nxt,
   output rsp_type   rsp
);

   function automatic est_type abs_diff(est_type a, est_type b);
      abs_diff = (a > b) ? (a - b) : (b - a);
   endfunction

   // Any difference beyond the estimated size
   function automatic logic strays_full(state_type s, est_type dx, est_type dy,
                                        est_type dw, est_type dh);
      strays_full = (abs_diff(s.est_x, dx) > s.est_w) ||
                    (abs_diff(s.est_y, dy) > s.est_h) ||
                    (abs_diff(s.est_w, dw) > s.est_w) ||
                    (abs_diff(s.est_h, dh) > s.est_h);
   endfunction

   // 5 * |d| > 4 * size
   function automatic logic over_move(est_type diff, est_type size);
      logic [MOVE_W-1:0] five_d;
      logic [MOVE_W-1:0] four_s;
      five_d = {1'b0, diff, 2'b00} + MOVE_W'(diff);
      four_s = {1'b0, size, 2'b00};
      over_move = five_d > four_s;
   endfunction

   function automatic logic strays_move(state_type s, est_type dx, est_type dy,
                                        est_type dw, est_type dh);
      strays_move = over_move(abs_diff(s.est_x, dx), s.est_w) ||
                    over_move(abs_diff(s.est_y, dy), s.est_h) ||
                    over_move(abs_diff(s.est_w, dw), s.est_w) ||
                    over_move(abs_diff(s.est_h, dh), s.est_h);
   endfunction

   function automatic est_type average(est_type a, est_type b);
      logic [EST_W:0] sum;
      sum = {1'b0, a} + {1'b0, b};
      average = sum[EST_W:1];
   endfunction

   function automatic est_type to_fixed(logic [FIELD_W-1:0] v);
      to_fixed = {coord_type'(v), {FRAC_BITS{1'b0}}};
   endfunction

   est_type        d_x;
   est_type        d_y;
   est_type        d_w;
   est_type        d_h;
   event_type      ev;
   logic           cleared;
   logic [EST_W:0] right_sum;
   logic [EST_W:0] bottom_sum;

   assign d_x = to_fixed(req.center_x);
   assign d_y = to_fixed(req.center_y);
   assign d_w = to_fixed(req.obj_width);
   assign d_h = to_fixed(req.obj_height);

   always_comb begin
      nxt        = cur;
      ev         = EV_NONE;
      cleared    = 1'b0;
      right_sum  = '0;
      bottom_sum = '0;

      // Reload the estimate on the first detection after lock, in chroma mode
      if (cur.locked && cur.just_locked && cfg.chroma_mode) begin
         nxt.est_x = d_x;
         nxt.est_y = d_y;
         nxt.est_w = d_w;
         nxt.est_h = d_h;
      end
      if (cur.locked) begin
         nxt.just_locked = 1'b0;
      end

      if (!req.object_present) begin
         // Lost object: clear the attempt or the lock
         if (cur.locked) begin
            ev = cfg.chroma_mode ? EV_TRIGGER : EV_RESET;
         end else begin
            ev = (cur.lock_count != 3'd0) ? EV_RESET : EV_NONE;
         end
         cleared = 1'b1;
      end else begin
         // Count consistent detections toward lock
         if (nxt.lock_count == 3'd0) begin
            nxt.est_x      = d_x;
            nxt.est_y      = d_y;
            nxt.est_w      = d_w;
            nxt.est_h      = d_h;
            nxt.lock_count = 3'd1;
         end else if (nxt.lock_count < 3'(LOCK_COUNT)) begin
            if (strays_full(nxt, d_x, d_y, d_w, d_h)) begin
               ev      = EV_RESET;
               cleared = 1'b1;
            end else begin
               nxt.est_x      = average(nxt.est_x, d_x);
               nxt.est_y      = average(nxt.est_y, d_y);
               nxt.est_w      = average(nxt.est_w, d_w);
               nxt.est_h      = average(nxt.est_h, d_h);
               nxt.lock_count = nxt.lock_count + 3'd1;
            end
         end

         // Take lock and publish the crop, or watch for movement
         if (!cleared && nxt.lock_count == 3'(LOCK_COUNT)) begin
            if (!nxt.locked) begin
               right_sum  = {1'b0, nxt.est_x} + {1'b0, nxt.est_w};
               bottom_sum = {1'b0, nxt.est_y} + {1'b0, nxt.est_h};
               nxt.crop_left   = (nxt.est_x > nxt.est_w) ?
                  CROP_W'((nxt.est_x - nxt.est_w) >> FRAC_BITS) : '0;
               nxt.crop_top    = (nxt.est_y > nxt.est_h) ?
                  CROP_W'((nxt.est_y - nxt.est_h) >> FRAC_BITS) : '0;
               nxt.crop_right  = right_sum[EST_W:FRAC_BITS];
               nxt.crop_bottom = bottom_sum[EST_W:FRAC_BITS];
               nxt.locked      = 1'b1;
               nxt.just_locked = 1'b1;
               ev              = EV_LOCK;
            end else if (strays_move(nxt, d_x, d_y, d_w, d_h)) begin
               ev      = EV_TRIGGER;
               cleared = 1'b1;
            end
         end
      end

      // Clear keeps the estimate and opens the crop to the full frame
      if (cleared) begin
         nxt.lock_count  = 3'd0;
         nxt.locked      = 1'b0;
         nxt.just_locked = 1'b0;
         nxt.crop_left   = '0;
         nxt.crop_top    = '0;
         nxt.crop_right  = CROP_W'(cfg.frame_width);
         nxt.crop_bottom = CROP_W'(cfg.frame_height);
      end
   end

   // Result taken after the update
   always_comb begin
      rsp.event_res     = ev;
      rsp.is_locked     = nxt.locked;
      rsp.lock_progress = nxt.lock_count;
      rsp.crop_left     = EDGE_W'(nxt.crop_left);
      rsp.crop_top      = EDGE_W'(nxt.crop_top);
      rsp.crop_right    = EDGE_W'(nxt.crop_right);
      rsp.crop_bottom   = EDGE_W'(nxt.crop_bottom);
      rsp.est_x         = FIELD_W'(nxt.est_x[EST_W-1:FRAC_BITS]);
      rsp.est_y         = FIELD_W'(nxt.est_y[EST_W-1:FRAC_BITS]);
   end

endmodule

[src/target_lock_qualifier_unit.sv]
// Top level of the target lock qualifier: request register, tracker state, result register.
//
//   channel  | ports                                   | direction
//   ---------+-----------------------------------------+----------
//   request  | req_valid, req_stall, req_data          | in
//   result   | rsp_valid, rsp_stall, rsp_data          | out
//   config   | csr_write_enable, csr_index, csr_data   | in
//
// A request passes through the request register and then the result register,
// one request per cycle sustained while the result side does not stall. The tracker
// state updates in the same cycle that the result register loads.
// Reset clears the state and the valid bits, not the payload registers; the crop
// rectangle starts at the full frame 640 x 480. A stall on the result side holds
// the result register; the request register then holds and stalls the requester.
module target_lock_qualifier_unit
   import tlq_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  req_type               req_data,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output rsp_type               rsp_data,
   input  logic                  csr_write_enable,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_data
);

   cfg_type   cfg;
   logic      in_valid_ff;
   logic      in_valid_in;
   req_type   in_data_ff;
   logic      rsp_valid_ff;
   logic      rsp_valid_in;
   rsp_type   rsp_data_ff;
   rsp_type   rsp_next;
   state_type state_ff;
   state_type state_next;
   logic      advance;
   logic      accept;

   tlq_csr u_csr (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_data         (csr_data),
      .cfg              (cfg)
   );

   tlq_update u_update (
      .cur (state_ff),
      .req (in_data_ff),
      .cfg (cfg),
      .nxt (state_next),
      .rsp (rsp_next)
   );

   // Move the held request to the result register when it is free
   assign advance      = in_valid_ff && (!rsp_valid_ff || !rsp_stall);
   assign req_stall    = in_valid_ff && !advance;
   assign accept       = req_valid && !req_stall;
   assign in_valid_in  = accept || (in_valid_ff && !advance);
   assign rsp_valid_in = advance || (rsp_valid_ff && rsp_stall);

   // Hold control state
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff           <= 1'b0;
         rsp_valid_ff          <= 1'b0;
         state_ff.est_x        <= '0;
         state_ff.est_y        <= '0;
         state_ff.est_w        <= '0;
         state_ff.est_h        <= '0;
         state_ff.lock_count   <= 3'd0;
         state_ff.locked       <= 1'b0;
         state_ff.just_locked  <= 1'b0;
         state_ff.crop_left    <= '0;
         state_ff.crop_top     <= '0;
         state_ff.crop_right   <= CROP_W'(FRAME_WIDTH_RESET);
         state_ff.crop_bottom  <= CROP_W'(FRAME_HEIGHT_RESET);
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         if (advance) begin
            state_ff <= state_next;
         end
      end
   end

   // Load payload registers
   always_ff @(posedge clock) begin
      if (accept) begin
         in_data_ff <= req_data;
      end
      if (advance) begin
         rsp_data_ff <= rsp_next;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

[bench/tb.sv]
// Self-checking testbench for the target lock qualifier: predictor, driver, monitor, watchdog.
`timescale 1ns / 1ps

module tb;
   import tlq_pkg::*;

   localparam int WATCHDOG_LIMIT = 3000;
   localparam int PHASE_ITEMS    = 145;
   localparam int RANDOM_PHASES  = 8;

   // Index past the register list, written to check that it is dropped
   localparam logic [CSR_IDX_W-1:0] CSR_UNUSED_INDEX = 2'd3;

   logic                  clock;
   logic                  reset            = 1'b1;
   logic                  req_valid        = 1'b0;
   logic                  req_stall;
   req_type               req_data         = '0;
   logic                  rsp_valid;
   logic                  rsp_stall        = 1'b0;
   rsp_type               rsp_data;
   logic                  csr_write_enable = 1'b0;
   logic [CSR_IDX_W-1:0]  csr_index        = '0;
   logic [CSR_DATA_W-1:0] csr_data         = '0;

   target_lock_qualifier_unit dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_data         (req_data),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_data         (rsp_data),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_data         (csr_data)
   );

   // Tracker copy: configuration and state
   logic [CSR_DATA_W-1:0] cfg_fw;
   logic [CSR_DATA_W-1:0] cfg_fh;
   logic                  cfg_chroma;
   est_type               trk_x, trk_y, trk_w, trk_h;
   logic [2:0]            trk_count;
   logic                  trk_locked;
   logic                  trk_just_locked;
   crop_type              crop_l, crop_t, crop_r, crop_b;

   req_type pending_req[$];
   rsp_type expected_rsp[$];
   int      queued_items   = 0;
   int      failures       = 0;
   int      quiet_cycles   = 0;
   int      send_gap       = 0;
   int      recv_gap       = 0;
   int      send_idle_rate = 0;
   int      recv_idle_rate = 0;

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   function automatic int unsigned abs_gap(est_type a, est_type b);
      return (a > b) ? 32'(a) - 32'(b) : 32'(b) - 32'(a);
   endfunction

   // Drop the lock attempt and fall back to the full frame
   function automatic void clear_track();
      trk_just_locked = 1'b0;
      trk_locked      = 1'b0;
      trk_count       = '0;
      crop_l          = '0;
      crop_t          = '0;
      crop_r          = crop_type'(cfg_fw);
      crop_b          = crop_type'(cfg_fh);
   endfunction

   // True when any difference exceeds num/den of the estimated size
   function automatic bit strays(est_type dx, est_type dy, est_type dw, est_type dh,
                                 int unsigned num, int unsigned den);
      return abs_gap(trk_x, dx) * den > 32'(trk_w) * num
          || abs_gap(trk_y, dy) * den > 32'(trk_h) * num
          || abs_gap(trk_w, dw) * den > 32'(trk_w) * num
          || abs_gap(trk_h, dh) * den > 32'(trk_h) * num;
   endfunction

   function automatic void load_estimate(est_type dx, est_type dy, est_type dw, est_type dh);
      trk_x = dx;
      trk_y = dy;
      trk_w = dw;
      trk_h = dh;
   endfunction

   // Advance the tracker by one detection and form the result it produces
   function automatic rsp_type track_step(req_type r);
      est_type   dx, dy, dw, dh;
      event_type ev;
      bit        rejected;
      rsp_type   o;
      dx = est_type'(32'(r.center_x[COORD_BITS-1:0]) << FRAC_BITS);
      dy = est_type'(32'(r.center_y[COORD_BITS-1:0]) << FRAC_BITS);
      dw = est_type'(32'(r.obj_width[COORD_BITS-1:0]) << FRAC_BITS);
      dh = est_type'(32'(r.obj_height[COORD_BITS-1:0]) << FRAC_BITS);
      ev = EV_NONE;
      rejected = 1'b0;
      // reload on the first frame after lock, in chroma mode
      if (trk_locked && trk_just_locked) begin
         if (cfg_chroma) load_estimate(dx, dy, dw, dh);
         trk_just_locked = 1'b0;
      end
      if (r.object_present) begin
         if (trk_count == 0) begin
            load_estimate(dx, dy, dw, dh);
            trk_count = 3'd1;
         end else if (trk_count < LOCK_COUNT) begin
            if (strays(dx, dy, dw, dh, 1, 1)) begin
               clear_track();
               ev = EV_RESET;
               rejected = 1'b1;
            end else begin
               trk_x = est_type'((32'(trk_x) + 32'(dx)) >> 1);
               trk_y = est_type'((32'(trk_y) + 32'(dy)) >> 1);
               trk_w = est_type'((32'(trk_w) + 32'(dw)) >> 1);
               trk_h = est_type'((32'(trk_h) + 32'(dh)) >> 1);
               trk_count = trk_count + 3'd1;
            end
         end
         if (!rejected && trk_count == LOCK_COUNT) begin
            if (!trk_locked) begin
               crop_l = (trk_x > trk_w) ?
                        crop_type'((32'(trk_x) - 32'(trk_w)) >> FRAC_BITS) : '0;
               crop_t = (trk_y > trk_h) ?
                        crop_type'((32'(trk_y) - 32'(trk_h)) >> FRAC_BITS) : '0;
               crop_r = crop_type'((32'(trk_x) + 32'(trk_w)) >> FRAC_BITS);
               crop_b = crop_type'((32'(trk_y) + 32'(trk_h)) >> FRAC_BITS);
               trk_locked      = 1'b1;
               trk_just_locked = 1'b1;
               ev = EV_LOCK;
            end else if (strays(dx, dy, dw, dh, 4, 5)) begin
               clear_track();
               ev = EV_TRIGGER;
            end
         end
      end else begin
         if (trk_locked) ev = cfg_chroma ? EV_TRIGGER : EV_RESET;
         else ev = (trk_count != 0) ? EV_RESET : EV_NONE;
         clear_track();
      end
      o.event_res     = ev;
      o.is_locked     = trk_locked;
      o.lock_progress = trk_count;
      o.crop_left     = crop_l;
      o.crop_top      = crop_t;
      o.crop_right    = crop_r;
      o.crop_bottom   = crop_b;
      o.est_x         = FIELD_W'(trk_x >> FRAC_BITS);
      o.est_y         = FIELD_W'(trk_y >> FRAC_BITS);
      return o;
   endfunction

   function automatic void check_field(string name, int unsigned want, int unsigned got);
      if (want != got) begin
         $error("%s: expected %0d, actual %0d", name, want, got);
         failures++;
      end
   endfunction

   function automatic void check_rsp(rsp_type got, rsp_type want);
      check_field("event_res", want.event_res, got.event_res);
      check_field("is_locked", want.is_locked, got.is_locked);
      check_field("lock_progress", want.lock_progress, got.lock_progress);
      check_field("crop_left", want.crop_left, got.crop_left);
      check_field("crop_top", want.crop_top, got.crop_top);
      check_field("crop_right", want.crop_right, got.crop_right);
      check_field("crop_bottom", want.crop_bottom, got.crop_bottom);
      check_field("est_x", want.est_x, got.est_x);
      check_field("est_y", want.est_y, got.est_y);
   endfunction

   function automatic void add_det(bit p, int x, int y, int w, int h);
      req_type r;
      r.object_present = p;
      r.center_x       = FIELD_W'(x);
      r.center_y       = FIELD_W'(y);
      r.obj_width      = FIELD_W'(w);
      r.obj_height     = FIELD_W'(h);
      pending_req.push_back(r);
      queued_items++;
   endfunction

   // Value within +/- span of v, held inside the field range
   function automatic int near(int v, int span);
      int r;
      r = v + int'($urandom_range(0, 2 * span)) - span;
      if (r < 0) r = 0;
      if (r > 4095) r = 4095;
      return r;
   endfunction

   // A burst of detections around one target, mostly steady, sometimes drifting, now and then absent
   function automatic void add_track_run();
      int cx, cy, w, h, len, pct;
      cx = $urandom_range(0, 4095);
      cy = $urandom_range(0, 4095);
      if ($urandom_range(0, 3) == 0) begin
         w = $urandom_range(0, 4095);
         h = $urandom_range(0, 4095);
      end else begin
         w = $urandom_range(1, 80);
         h = $urandom_range(1, 80);
      end
      len = $urandom_range(1, 14);
      for (int i = 0; i < len; i++) begin
         pct = ($urandom_range(0, 2) != 0) ? $urandom_range(0, 40) : $urandom_range(0, 130);
         add_det(1'b1, near(cx, w * pct / 100), near(cy, h * pct / 100),
                 near(w, w * pct / 100), near(h, h * pct / 100));
         if ($urandom_range(0, 19) == 0)
            add_det(1'b0, $urandom_range(0, 4095), $urandom_range(0, 4095),
                    $urandom_range(0, 4095), $urandom_range(0, 4095));
      end
   endfunction

   task automatic write_reg(logic [CSR_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] value);
      @(posedge clock);
      csr_write_enable <= 1'b1;
      csr_index        <= idx;
      csr_data         <= value;
      case (idx)
         CSR_FRAME_WIDTH:  cfg_fw = value;
         CSR_FRAME_HEIGHT: cfg_fh = value;
         CSR_CHROMA_MODE:  cfg_chroma = value[0];
         default: ;
      endcase
      @(posedge clock);
      csr_write_enable <= 1'b0;
   endtask

   // Hold until every queued request has been answered, then let the pipe settle
   task automatic drain();
      @(negedge clock);
      while (pending_req.size() != 0 || req_valid || expected_rsp.size() != 0)
         @(negedge clock);
      repeat (4) @(posedge clock);
   endtask

   // Request driver: predict on acceptance, then present the next request or idle
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         send_gap  <= 0;
      end else if (!req_valid || !req_stall) begin
         if (req_valid) expected_rsp.push_back(track_step(req_data));
         if (send_gap > 0) begin
            send_gap  <= send_gap - 1;
            req_valid <= 1'b0;
         end else if (pending_req.size() > 0) begin
            req_data  <= pending_req.pop_front();
            req_valid <= 1'b1;
            if (send_idle_rate != 0 && $urandom_range(0, send_idle_rate) == 0)
               send_gap <= $urandom_range(1, 13);
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // Result monitor: check against the oldest prediction, stall in bursts
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
         recv_gap  <= 0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_rsp.size() == 0) begin
               $error("result with no request waiting");
               failures++;
            end else begin
               check_rsp(rsp_data, expected_rsp.pop_front());
            end
         end
         if (recv_gap > 0) begin
            recv_gap  <= recv_gap - 1;
            rsp_stall <= 1'b1;
         end else if (recv_idle_rate != 0 && $urandom_range(0, recv_idle_rate) == 0) begin
            recv_gap  <= $urandom_range(0, 12);
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   // Count cycles with no handshake on either channel
   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
   end

   initial begin
      wait (quiet_cycles >= WATCHDOG_LIMIT);
      $display("== FAIL ==");
      $finish;
   end

   initial begin
      int target;
      int mode;
      cfg_fw     = FRAME_WIDTH_RESET;
      cfg_fh     = FRAME_HEIGHT_RESET;
      cfg_chroma = CHROMA_MODE_RESET;
      load_estimate('0, '0, '0, '0);
      clear_track();
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      send_idle_rate = 3;
      recv_idle_rate = 3;

      // Directed: reset settings, chroma mode on
      add_det(1'b0, 0, 0, 0, 0);                       // nothing tracked, absent
      repeat (5) add_det(1'b1, 100, 80, 20, 10);       // build up to lock
      add_det(1'b1, 100, 80, 20, 10);                  // reload after lock
      add_det(1'b1, 130, 80, 20, 10);                  // moved past the trigger band
      add_det(1'b1, 4095, 4095, 4095, 4095);           // largest fields load
      add_det(1'b0, 4095, 4095, 4095, 4095);           // lost during attempt
      repeat (5) add_det(1'b1, 0, 0, 0, 0);            // zero size still locks
      add_det(1'b0, 0, 0, 0, 0);                       // lost while locked
      add_det(1'b1, 2000, 2000, 100, 100);
      add_det(1'b1, 2200, 2000, 100, 100);             // strays during attempt
      drain();

      // Directed: smallest frame, chroma mode off, unused index
      write_reg(CSR_FRAME_WIDTH, 12'd1);
      write_reg(CSR_FRAME_HEIGHT, 12'd1);
      write_reg(CSR_CHROMA_MODE, 12'd0);
      write_reg(CSR_UNUSED_INDEX, 12'hFFF);
      repeat (5) add_det(1'b1, 4095, 4095, 4095, 4095);
      add_det(1'b0, 4095, 4095, 4095, 4095);           // lost while locked, no trigger
      repeat (5) add_det(1'b1, 300, 300, 40, 40);
      add_det(1'b1, 340, 300, 40, 40);                 // moved, no reload
      drain();

      // Random phases
      for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
         mode = $urandom_range(0, 3);
         write_reg(CSR_FRAME_WIDTH, (mode == 0) ? 12'd1 : (mode == 1) ? 12'd4095 :
                                    CSR_DATA_W'($urandom_range(1, 4095)));
         mode = $urandom_range(0, 3);
         write_reg(CSR_FRAME_HEIGHT, (mode == 0) ? 12'd1 : (mode == 1) ? 12'd4095 :
                                     CSR_DATA_W'($urandom_range(1, 4095)));
         write_reg(CSR_CHROMA_MODE,
                   {(CSR_DATA_W-1)'($urandom_range(0, 2047)), 1'(ph % 2)});
         if (ph == RANDOM_PHASES - 1) begin
            send_idle_rate = 0;
            recv_idle_rate = 0;
         end else begin
            send_idle_rate = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(2, 8);
            recv_idle_rate = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(2, 8);
         end
         target = queued_items + PHASE_ITEMS;
         while (queued_items < target) begin
            mode = $urandom_range(0, 9);
            if (mode == 0)
               add_det(1'($urandom_range(0, 1)), $urandom_range(0, 4095),
                       $urandom_range(0, 4095), $urandom_range(0, 4095),
                       $urandom_range(0, 4095));
            else if (mode == 1)
               add_det(1'b0, $urandom_range(0, 4095), $urandom_range(0, 4095),
                       $urandom_range(0, 4095), $urandom_range(0, 4095));
            else
               add_track_run();
         end
         drain();
      end

      repeat (8) @(posedge clock);
      if (failures == 0) $display("== PASS ==");
      else $display("== FAIL ==");
      $finish;
   end

endmodule
